// ===== src/rtt_pkg.sv =====
// Shared types and constants of the retransmit transaction table.
// No dependencies; every other file of the block but rtt_if imports this package.
`timescale 1ns / 1ps

package rtt_pkg;

  // Field widths
  localparam int ID_W   = 16;
  localparam int IV_W   = 24;
  localparam int RTY_W  = 3;
  localparam int SLOT_W = 3;
  localparam int CFG_W  = 16;

  // Interval saturation limits
  localparam logic [IV_W-1:0] IV_MAX  = 24'hFFFFFF;
  localparam logic [IV_W-1:0] IV_HALF = 24'h7FFFFF;

  // At most this many expiries are reported per tick
  localparam int              CNT_W       = 4;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd8;

  // Remainder unit: one quotient bit per step
  localparam int              DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd16;

  // Configuration register indexes
  localparam int              CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTX = 2'd2;

  typedef enum logic [1:0] {
    CMD_OPEN = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_SENT      = 3'd0,
    EV_RETX      = 3'd1,
    EV_TIMEOUT   = 3'd2,
    EV_ACKED     = 3'd3,
    EV_NOT_FOUND = 3'd4,
    EV_FULL      = 3'd5,
    EV_TICK_IDLE = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_EVAL,
    S_FIN
  } state_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]  msg_id;
    logic [RTY_W-1:0] retry;
    logic [IV_W-1:0]  armed;
    logic [IV_W-1:0]  remaining;
  } entry_t;

  // One result item
  typedef struct packed {
    event_t            ev;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   msg_id;
    logic [RTY_W-1:0]  attempt;
    logic [IV_W-1:0]   interval;
    logic              last;
  } result_t;

  // Configuration register values
  typedef struct packed {
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] modulus;
    logic [RTY_W-1:0] max_rtx;
  } cfg_t;

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/rtt_if.sv =====
// Valid/ready channel interfaces of the retransmit transaction table.
// Command channel and result channel; no dependencies.
`timescale 1ns / 1ps

interface rtt_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] msg_id;
  logic        confirmable;
  logic [15:0] rand_value;

  modport source (output valid, cmd, msg_id, confirmable, rand_value, input ready);
  modport sink   (input valid, cmd, msg_id, confirmable, rand_value, output ready);
endinterface

interface rtt_out_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  slot;
  logic [15:0] event_msg_id;
  logic [2:0]  attempt;
  logic [23:0] new_interval;
  logic        last;

  modport source (output valid, event_res, slot, event_msg_id, attempt, new_interval, last,
                  input ready);
  modport sink   (input valid, event_res, slot, event_msg_id, attempt, new_interval, last,
                  output ready);
endinterface

// ===== src/retransmit_transaction_table.sv =====
// Top level of the retransmit transaction table: configuration registers,
// slot memory, remainder unit and sequencer. Depends on rtt_pkg, rtt_if,
// rtt_mem, rtt_div and rtt_seq.
//
//   port     dir  handshake         payload
//   in_ch    in   valid/ready       cmd, msg_id, confirmable, rand_value
//   out_ch   out  valid/ready       event_res, slot, event_msg_id, attempt,
//                                   new_interval, last
//   cfg_*    in   cfg_we            cfg_index, cfg_wdata
//
// A non-confirmable open or a full table goes straight to S_FIN; a confirmable
// open waits for the bit-serial remainder unit, skipped when the modulus is zero.
// Acknowledge and tick scan one slot per cycle over the separate read and write
// ports of the slot memory, stalling on an expiry while the output is full.
// Reset clears the valid bits, sequencer and output register; slot memory
// contents are not cleared. A full output register holds a tick scan at the
// next expiry until the waiting result is taken; a new command is taken
// while the last result of the previous one still waits.
`timescale 1ns / 1ps

module retransmit_transaction_table
  import rtt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rtt_in_if.sink               in_ch,
  rtt_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  cfg_t          cfg_r, cfg_nxt;
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:    cfg_nxt.base    = cfg_wdata;
        CFG_MODULUS: cfg_nxt.modulus = cfg_wdata;
        CFG_MAX_RTX: cfg_nxt.max_rtx = cfg_wdata[RTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base    <= 16'd256;
      cfg_r.modulus <= 16'd129;
      cfg_r.max_rtx <= 3'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rtt_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rtt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rtt_seq #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== src/rtt_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on rtt_pkg for the entry type.
`timescale 1ns / 1ps

module rtt_mem
  import rtt_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rtt_div.sv =====
// Bit-serial remainder unit (restoring), one dividend bit per cycle.
// Depends on rtt_pkg for the request/response structs.
`timescale 1ns / 1ps

module rtt_div
  import rtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]     dvd_r, dvd_nxt;
  logic [CFG_W-1:0]     dvs_r, dvs_nxt;
  logic [CFG_W:0]       trial;
  logic                 fits;

  // One restoring step
  always_comb begin
    trial    = {rem_r, dvd_r[CFG_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? CFG_W'(trial - {1'b0, dvs_r}) : trial[CFG_W-1:0];
      dvd_nxt = {dvd_r[CFG_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/rtt_seq.sv =====
// Sequencer: command decode, slot scans over the memory, valid bits,
// pending result and output register. Depends on rtt_pkg and rtt_if.
`timescale 1ns / 1ps

module rtt_seq
  import rtt_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int AW    = 3,
  parameter int CW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  rtt_in_if.sink        in_ch,
  rtt_out_if.source     out_ch,
  input  cfg_t          cfg,
  output div_req_t      div_req,
  input  div_rsp_t      div_rsp,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [CFG_W-1:0]   add_r, add_nxt;
  logic               tick_r, tick_nxt;
  logic               pend_v_r, pend_v_nxt;
  result_t            pend_r, pend_nxt;
  logic               out_v_r, out_v_nxt;
  result_t            out_r, out_nxt;

  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic               out_free;
  logic               push;
  result_t            push_pl;
  logic               adv;
  logic               cur_valid;
  logic               expire;
  logic [IV_W-1:0]    rem_dec;
  logic [IV_W-1:0]    iv_dbl;
  logic [IV_W-1:0]    iv_first;
  logic [CW-1:0]      idx_inc;
  logic [SLOT_W-1:0]  slot_cur;

  // Lowest free slot for an open
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_found = 1'b1;
        free_idx   = AW'(k);
      end
    end
  end

  // Per-slot arithmetic on the entry just read
  always_comb begin
    cur_valid = valid_r[idx_r[AW-1:0]];
    rem_dec   = (mem_rdata.remaining == '0) ? '0 : mem_rdata.remaining - 1'b1;
    iv_dbl    = (mem_rdata.armed > IV_HALF) ? IV_MAX : {mem_rdata.armed[IV_W-2:0], 1'b0};
    expire    = (rem_dec == '0) && (n_r < MAX_RESULTS);
    iv_first  = IV_W'(cfg.base) + IV_W'(add_r);
    idx_inc   = idx_r + 1'b1;
    slot_cur  = SLOT_W'(idx_r);
    out_free  = !out_v_r || out_ch.ready;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    valid_nxt  = valid_r;
    id_nxt     = id_r;
    add_nxt    = add_r;
    tick_nxt   = tick_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_nxt    = out_r;
    push       = 1'b0;
    push_pl    = pend_r;
    adv        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    div_req    = '0;
    in_ch.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt = in_ch.msg_id;
          case (cmd_t'(in_ch.cmd))
            CMD_OPEN: begin
              if (!free_found) begin
                pend_nxt   = '{ev: EV_FULL, slot: '0, msg_id: in_ch.msg_id, attempt: '0,
                               interval: '0, last: 1'b0};
                pend_v_nxt = 1'b1;
                state_nxt  = S_FIN;
              end else if (!in_ch.confirmable) begin
                pend_nxt   = '{ev: EV_SENT, slot: SLOT_W'(free_idx), msg_id: in_ch.msg_id,
                               attempt: '0, interval: '0, last: 1'b0};
                pend_v_nxt = 1'b1;
                state_nxt  = S_FIN;
              end else begin
                idx_nxt = CW'(free_idx);
                if (cfg.modulus == '0) begin
                  add_nxt   = '0;
                  state_nxt = S_WRITE;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = in_ch.rand_value;
                  div_req.divisor  = cfg.modulus;
                  state_nxt        = S_DIV;
                end
              end
            end
            CMD_ACK: begin
              // Default answer is "not found"; a match overwrites it
              tick_nxt   = 1'b0;
              pend_nxt   = '{ev: EV_NOT_FOUND, slot: '0, msg_id: in_ch.msg_id, attempt: '0,
                             interval: '0, last: 1'b0};
              pend_v_nxt = 1'b1;
              idx_nxt    = '0;
              mem_re     = 1'b1;
              state_nxt  = S_EVAL;
            end
            CMD_TICK: begin
              tick_nxt  = 1'b1;
              n_nxt     = '0;
              idx_nxt   = '0;
              mem_re    = 1'b1;
              state_nxt = S_EVAL;
            end
            default: begin
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          add_nxt   = div_rsp.rem;
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        mem_we                    = 1'b1;
        mem_wdata                 = '{msg_id: id_r, retry: '0, armed: iv_first,
                                      remaining: iv_first};
        valid_nxt[idx_r[AW-1:0]]  = 1'b1;
        pend_nxt   = '{ev: EV_SENT, slot: slot_cur, msg_id: id_r, attempt: '0,
                       interval: iv_first, last: 1'b0};
        pend_v_nxt = 1'b1;
        state_nxt  = S_FIN;
      end

      S_EVAL: begin
        if (!tick_r) begin
          // Acknowledge search
          if (cur_valid && mem_rdata.msg_id == id_r) begin
            valid_nxt[idx_r[AW-1:0]] = 1'b0;
            pend_nxt  = '{ev: EV_ACKED, slot: slot_cur, msg_id: id_r,
                          attempt: mem_rdata.retry, interval: '0, last: 1'b0};
            state_nxt = S_FIN;
          end else begin
            adv = 1'b1;
          end
        end else if (!cur_valid) begin
          adv = 1'b1;
        end else if (!expire) begin
          // Count down, saturating at zero
          mem_we              = 1'b1;
          mem_wdata.remaining = rem_dec;
          adv                 = 1'b1;
        end else if (!(pend_v_r && !out_free)) begin
          // Expiry: release the previous result, this one becomes pending
          push  = pend_v_r;
          n_nxt = n_r + 1'b1;
          if (mem_rdata.retry < cfg.max_rtx) begin
            mem_we     = 1'b1;
            mem_wdata  = '{msg_id: mem_rdata.msg_id, retry: mem_rdata.retry + 1'b1,
                           armed: iv_dbl, remaining: iv_dbl};
            pend_nxt   = '{ev: EV_RETX, slot: slot_cur, msg_id: mem_rdata.msg_id,
                           attempt: mem_rdata.retry + 1'b1, interval: iv_dbl, last: 1'b0};
          end else begin
            valid_nxt[idx_r[AW-1:0]] = 1'b0;
            pend_nxt   = '{ev: EV_TIMEOUT, slot: slot_cur, msg_id: mem_rdata.msg_id,
                           attempt: mem_rdata.retry, interval: '0, last: 1'b0};
          end
          pend_v_nxt = 1'b1;
          adv        = 1'b1;
        end

        // Step to the next slot, reading it while this one is written back
        if (adv) begin
          if (idx_inc == CW'(SLOTS)) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc[AW-1:0];
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          push = 1'b1;
          // A tick without expiries reports idle
          if (!pend_v_r) begin
            push_pl = '{ev: EV_TICK_IDLE, slot: '0, msg_id: '0, attempt: '0,
                        interval: '0, last: 1'b0};
          end
          push_pl.last = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = push_pl;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      n_r      <= '0;
      tick_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
      n_r      <= n_nxt;
      tick_r   <= tick_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    add_r  <= add_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.event_res    = out_r.ev;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.event_msg_id = out_r.msg_id;
  assign out_ch.attempt      = out_r.attempt;
  assign out_ch.new_interval = out_r.interval;
  assign out_ch.last         = out_r.last;

`ifndef ASSERT_OFF
  // No more expiries than allowed are ever counted in one tick
  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_RESULTS)
    else $error("expiry count exceeds limit");

  // The remainder unit only answers while an open waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("remainder unit done outside wait state");

  // Nothing is left pending once the block is idle again
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("pending result left behind");

  // The slot memory is written only on open or during a tick scan
  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WRITE || (state_r == S_EVAL && tick_r)))
    else $error("unexpected slot memory write");

  // A pending result is never overwritten while it cannot be released
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && tick_r && pend_v_r && !out_free) |=> $stable(pend_r))
    else $error("pending result lost");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the retransmit transaction table.
// Depends on rtt_pkg, the rtt_in_if/rtt_out_if channels and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import rtt_pkg::*;

  localparam int SLOTS = 8;
  localparam int STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] id;
    logic        con;
    logic [15:0] rnd;
  } command_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  rtt_in_if  in_ch ();
  rtt_out_if out_ch ();

  retransmit_transaction_table #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and expectation stores
  command_t pending_cmds[$];
  result_t  expected_events[$];

  // Shadow of the table and its registers
  logic        slot_busy[SLOTS];
  logic [15:0] slot_id[SLOTS];
  logic [2:0]  slot_retry[SLOTS];
  logic [23:0] slot_armed[SLOTS];
  logic [23:0] slot_left[SLOTS];
  logic [15:0] set_base = 16'd256;
  logic [15:0] set_modulus = 16'd129;
  logic [2:0]  set_max_rtx = 3'd4;

  int err_count = 0;
  int cmds_taken = 0;
  int events_checked = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left = 0;
  bit stall_arm = 1'b0;
  bit in_took = 1'b0;
  logic [15:0] id_pool[6];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_id[i] = '0;
      slot_retry[i] = '0;
      slot_armed[i] = '0;
      slot_left[i] = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.msg_id = '0;
    in_ch.confirmable = 1'b0;
    in_ch.rand_value = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------
  function automatic void push_event(event_t ev, int slot, logic [15:0] id,
                                     logic [2:0] att, logic [23:0] iv);
    result_t r;
    r.ev = ev;
    r.slot = slot[2:0];
    r.msg_id = id;
    r.attempt = att;
    r.interval = iv;
    r.last = 1'b0;
    expected_events.push_back(r);
  endfunction

  function automatic void predict_command(cmd_t c, logic [15:0] id, logic con,
                                          logic [15:0] rnd);
    int          n;
    int          i;
    logic [23:0] iv;
    result_t     r;
    n = 0;
    case (c)
      CMD_OPEN: begin
        i = 0;
        while (i < SLOTS && slot_busy[i]) i++;
        if (i == SLOTS) begin
          push_event(EV_FULL, 0, id, 3'd0, 24'd0);
        end else if (!con) begin
          push_event(EV_SENT, i, id, 3'd0, 24'd0);
        end else begin
          iv = 24'(set_base);
          if (set_modulus != 0) iv = iv + 24'(rnd % set_modulus);
          slot_busy[i] = 1'b1;
          slot_id[i] = id;
          slot_retry[i] = 3'd0;
          slot_armed[i] = iv;
          slot_left[i] = iv;
          push_event(EV_SENT, i, id, 3'd0, iv);
        end
        n = 1;
      end
      CMD_ACK: begin
        i = 0;
        while (i < SLOTS && !(slot_busy[i] && slot_id[i] == id)) i++;
        if (i == SLOTS) begin
          push_event(EV_NOT_FOUND, 0, id, 3'd0, 24'd0);
        end else begin
          slot_busy[i] = 1'b0;
          push_event(EV_ACKED, i, id, slot_retry[i], 24'd0);
        end
        n = 1;
      end
      CMD_TICK: begin
        // Count down in slot order; expiry either backs off or retires the slot
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_busy[i]) continue;
          if (slot_left[i] != 0) slot_left[i] = slot_left[i] - 24'd1;
          if (slot_left[i] != 0 || n >= int'(MAX_RESULTS)) continue;
          if (slot_retry[i] < set_max_rtx) begin
            iv = (slot_armed[i] > IV_HALF) ? IV_MAX : {slot_armed[i][22:0], 1'b0};
            slot_retry[i] = slot_retry[i] + 3'd1;
            slot_armed[i] = iv;
            slot_left[i] = iv;
            push_event(EV_RETX, i, slot_id[i], slot_retry[i], iv);
          end else begin
            slot_busy[i] = 1'b0;
            push_event(EV_TIMEOUT, i, slot_id[i], slot_retry[i], 24'd0);
          end
          n++;
        end
        if (n == 0) begin
          push_event(EV_TICK_IDLE, 0, 16'd0, 3'd0, 24'd0);
          n = 1;
        end
      end
      default: ;
    endcase
    // Flag the final result of this command
    if (n != 0) begin
      r = expected_events.pop_back();
      r.last = 1'b1;
      expected_events.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("tb: %s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Rising edge: check results, predict accepted commands, track registers
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        $error("tb: result with nothing expected: event %0d slot %0d id %0d",
               out_ch.event_res, out_ch.slot, out_ch.event_msg_id);
        err_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", 32'(want.ev), 32'(out_ch.event_res));
        check_field("slot", 32'(want.slot), 32'(out_ch.slot));
        check_field("event_msg_id", 32'(want.msg_id), 32'(out_ch.event_msg_id));
        check_field("attempt", 32'(want.attempt), 32'(out_ch.attempt));
        check_field("new_interval", 32'(want.interval), 32'(out_ch.new_interval));
        check_field("last", 32'(want.last), 32'(out_ch.last));
        events_checked++;
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_command(cmd_t'(in_ch.cmd), in_ch.msg_id, in_ch.confirmable,
                      in_ch.rand_value);
      cmds_taken++;
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_BASE:    set_base = cfg_wdata;
        CFG_MODULUS: set_modulus = cfg_wdata;
        CFG_MAX_RTX: set_max_rtx = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Falling edge: command driver, long hold-off counter, result receiver
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : driver
    command_t nxt;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nxt.cmd;
        in_ch.msg_id <= nxt.id;
        in_ch.confirmable <= nxt.con;
        in_ch.rand_value <= nxt.rnd;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_arm) begin
      stall_arm = 1'b0;
      stall_left <= STALL_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && stall_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // ---------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------
  function automatic void add_cmd(cmd_t c, logic [15:0] id, logic con, logic [15:0] rnd);
    command_t t;
    t.cmd = c;
    t.id = id;
    t.con = con;
    t.rnd = rnd;
    pending_cmds.push_back(t);
  endfunction

  task automatic write_settings(input logic [15:0] base, input logic [15:0] modulus,
                                input logic [2:0] max_rtx);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_MODULUS;
    cfg_wdata <= modulus;
    @(negedge clk);
    cfg_index <= CFG_MAX_RTX;
    cfg_wdata <= {13'd0, max_rtx};
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // Wait for every transfer to finish, then let the sequencer settle
  task automatic drain();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly ids from a small pool so acknowledges and duplicates hit
  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 15) return 16'($urandom_range(65535));
    return id_pool[$urandom_range(5)];
  endfunction

  function automatic void queue_traffic(int count);
    int made;
    int roll;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (roll < 38) begin
        add_cmd(CMD_OPEN, pick_id(), $urandom_range(99) < 80, 16'($urandom_range(65535)));
        made++;
      end else if (roll < 58) begin
        add_cmd(CMD_ACK, pick_id(), 1'($urandom_range(1)), 16'($urandom_range(65535)));
        made++;
      end else if (roll < 97) begin
        add_cmd(CMD_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                16'($urandom_range(65535)));
        made++;
      end else begin
        add_cmd(CMD_NONE, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                16'($urandom_range(65535)));
      end
    end
  endfunction

  // mode: 0 no idling, 1 sender idles, 2 receiver stalls, 3 both lightly
  task automatic run_phase(input int mode, input logic [15:0] base,
                           input logic [15:0] modulus, input logic [2:0] max_rtx,
                           input bit hold);
    write_settings(base, modulus, max_rtx);
    send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 7 : 0;
    recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 7 : 0;
    for (int k = 0; k < 6; k++) id_pool[k] = 16'($urandom_range(65535));
    if (hold) stall_arm = 1'b1;
    queue_traffic(55);
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme ids, duplicate id, ack miss, non-confirmable,
    // backoff then timeout, full table, unused command
    write_settings(16'd2, 16'd3, 3'd1);
    add_cmd(CMD_OPEN, 16'h0000, 1'b1, 16'h0000);
    add_cmd(CMD_OPEN, 16'hFFFF, 1'b1, 16'hFFFF);
    add_cmd(CMD_OPEN, 16'h1234, 1'b0, 16'h0007);
    add_cmd(CMD_ACK, 16'hFFFF, 1'b0, 16'h0000);
    add_cmd(CMD_ACK, 16'h5555, 1'b0, 16'h0000);
    add_cmd(CMD_OPEN, 16'h0000, 1'b1, 16'h0001);
    add_cmd(CMD_ACK, 16'h0000, 1'b1, 16'hFFFF);
    for (int k = 0; k < 9; k++) add_cmd(CMD_TICK, 16'hFFFF, 1'b1, 16'hFFFF);
    for (int k = 0; k < 8; k++) add_cmd(CMD_OPEN, 16'(16'h8000 + k), 1'b1, 16'(k * 4099));
    add_cmd(CMD_OPEN, 16'hA5A5, 1'b1, 16'h5A5A);
    add_cmd(CMD_NONE, 16'hFFFF, 1'b1, 16'hFFFF);
    drain();

    run_phase(0, 16'd3, 16'd4, 3'd2, 1'b1);
    run_phase(1, 16'd1, 16'd0, 3'd7, 1'b0);
    run_phase(2, 16'd0, 16'd0, 3'd0, 1'b0);
    run_phase(3, 16'd5, 16'd65535, 3'd3, 1'b0);
    run_phase(0, 16'd65535, 16'd1, 3'd7, 1'b0);
    run_phase(1, 16'd2, 16'd6, 3'd4, 1'b0);
    run_phase(2, 16'd1, 16'd2, 3'd1, 1'b0);

    if (expected_events.size() != 0) begin
      $error("tb: %0d expected results never arrived", expected_events.size());
      err_count++;
    end
    $display("tb: %0d commands accepted, %0d results checked", cmds_taken, events_checked);
    $display("tb: %0d register settings, zero and full-scale values among them",
             settings_used);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
